>>> rtl/soc_pkg.sv
// shared types and constants for the segment/obstacle collision checker
// no dependencies; imported by every rtl module
package soc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int EXT_WIDTH   = 15;
    localparam int PAD_WIDTH   = 12;
    localparam int CNT_WIDTH   = 5;
    localparam int MAX_CIRCLES = 16;
    localparam int MAX_RECTS   = 16;
    localparam int IDX_WIDTH   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int MUL_W       = 37;
    localparam int ACC_W       = 76;

    // signed zero for accumulator sign tests
    localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;

    typedef enum logic [1:0] {
        OP_WR_CIRC = 2'd0,
        OP_WR_RECT = 2'd1,
        OP_CHECK   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_PADDING = 2'd0,
        CFG_CIRCLES = 2'd1,
        CFG_RECTS   = 2'd2,
        CFG_UNUSED  = 2'd3
    } t_cfg;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } t_mac_mode;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_D2A, ST_D2B, ST_D2C,
        ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5,
        ST_C6, ST_C7, ST_C8, ST_C9, ST_C10, ST_C11,
        ST_RI,
        ST_E0, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_mac_mode                mode;
        logic signed [MUL_W-1:0]  a;
        logic signed [MUL_W-1:0]  b;
    } t_mac_ctl;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic        [EXT_WIDTH-1:0]   r;
    } t_circ;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic        [EXT_WIDTH-1:0]   w;
        logic        [EXT_WIDTH-1:0]   h;
    } t_rect;

endpackage

>>> rtl/segment_obstacle_collision_check_top.sv
// segment versus circle/rectangle obstacle checker, top level with sequencer
// depends on soc_pkg, soc_mac, soc_tables
//
// Table writes and no-op words each give an all-zero result word in the next cycle. A check
// runs on one shared multiply-accumulate unit under a sequencer: first the
// segment length, then each circle in use and each rectangle in use (one
// inside test plus one test per padded edge), then the result is handed over. Input
// is stalled while a check runs and while an undelivered result word is held back
// by the output stall.
module segment_obstacle_collision_check_top
    import soc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [PAD_WIDTH-1:0]          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [IDX_WIDTH-1:0]          i_entry_index,
    input  logic signed [COORD_WIDTH-1:0] i_obstacle_x,
    input  logic signed [COORD_WIDTH-1:0] i_obstacle_y,
    input  logic [EXT_WIDTH-1:0]          i_obstacle_extent_a,
    input  logic [EXT_WIDTH-1:0]          i_obstacle_extent_b,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_collision,
    output logic                          o_endpoint_inside
);

    t_state r_state, n_state;
    t_op    op;
    logic   in_acc, out_free;

    logic [PAD_WIDTH-1:0] r_pad;
    logic [CNT_WIDTH-1:0] r_nc, r_nr, nc_eff, nr_eff;
    logic [IDX_WIDTH-1:0] r_idx;
    logic [1:0]           r_edge;
    logic                 r_inside, r_hit, r_nok;
    logic                 r_out_valid, r_out_coll, r_out_inside;

    logic signed [COORD_WIDTH-1:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [COORD_WIDTH:0]   r_dx, r_dy;
    logic signed [ACC_W-1:0]       r_d2, r_rr, r_t, r_cr, r_den, r_n1, acc;

    t_circ    circ;
    t_rect    rect;
    t_mac_ctl mac_ctl;

    logic last_circ, last_rect;

    // padded obstacle geometry
    logic signed [17:0] pad18, c_rad, x0, x1, y0, y1, ax, ay, bx, by;
    logic signed [17:0] dxs, dys, dxe, dye, wx, wy, ndy;
    logic signed [18:0] v1x, v1y, v2x, v2y;
    logic               den_pos, den_neg, cross_ok, ri_hit;

    assign op       = t_op'(i_operation);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_acc   = i_in_valid && !o_in_stall;

    assign nc_eff = (r_nc > CNT_WIDTH'(MAX_CIRCLES)) ? CNT_WIDTH'(MAX_CIRCLES) : r_nc;
    assign nr_eff = (r_nr > CNT_WIDTH'(MAX_RECTS)) ? CNT_WIDTH'(MAX_RECTS) : r_nr;
    assign last_circ = (CNT_WIDTH'(r_idx) + CNT_WIDTH'(1)) >= nc_eff;
    assign last_rect = (CNT_WIDTH'(r_idx) + CNT_WIDTH'(1)) >= nr_eff;

    soc_tables u_tables (
        .i_clk     (i_clk),
        .i_we_circ (in_acc && (op == OP_WR_CIRC)),
        .i_we_rect (in_acc && (op == OP_WR_RECT)),
        .i_wr_idx  (i_entry_index),
        .i_circ    ('{x: i_obstacle_x, y: i_obstacle_y, r: i_obstacle_extent_a}),
        .i_rect    ('{x: i_obstacle_x, y: i_obstacle_y,
                      w: i_obstacle_extent_a, h: i_obstacle_extent_b}),
        .i_rd_idx  (r_idx),
        .o_circ    (circ),
        .o_rect    (rect)
    );

    soc_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .o_acc (acc)
    );

    always_comb begin
        pad18 = signed'(18'(r_pad));
        c_rad = signed'(18'(circ.r) + 18'(r_pad));
        x0    = 18'(rect.x) - pad18;
        y0    = 18'(rect.y) - pad18;
        x1    = 18'(rect.x) + signed'(18'(rect.w)) + pad18;
        y1    = 18'(rect.y) + signed'(18'(rect.h)) + pad18;
        // edge order: bottom, right, top, left
        ax    = (r_edge == 2'd1 || r_edge == 2'd2) ? x1 : x0;
        ay    = r_edge[1] ? y1 : y0;
        bx    = (r_edge == 2'd0 || r_edge == 2'd1) ? x1 : x0;
        by    = (r_edge == 2'd1 || r_edge == 2'd2) ? y1 : y0;
        dxs   = 18'(r_sx) - 18'(circ.x);
        dys   = 18'(r_sy) - 18'(circ.y);
        dxe   = 18'(r_ex) - 18'(circ.x);
        dye   = 18'(r_ey) - 18'(circ.y);
        wx    = 18'(circ.x) - 18'(r_sx);
        wy    = 18'(circ.y) - 18'(r_sy);
        ndy   = -(18'(r_dy));
        v1x   = 19'(r_sx) - 19'(ax);
        v1y   = 19'(r_sy) - 19'(ay);
        v2x   = 19'(bx) - 19'(ax);
        v2y   = 19'(by) - 19'(ay);
        den_pos = r_den > ACC_ZERO;
        den_neg = r_den < ACC_ZERO;
        // acc holds the second numerator here
        cross_ok = (den_pos && r_n1 >= ACC_ZERO && r_n1 <= r_den
                            && acc >= ACC_ZERO && acc <= r_den)
                || (den_neg && r_n1 <= ACC_ZERO && r_n1 >= r_den
                            && acc <= ACC_ZERO && acc >= r_den);
        ri_hit = (18'(r_sx) >= x0 && 18'(r_sx) <= x1 && 18'(r_sy) >= y0 && 18'(r_sy) <= y1)
              || (18'(r_ex) >= x0 && 18'(r_ex) <= x1 && 18'(r_ey) >= y0 && 18'(r_ey) <= y1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && op == OP_CHECK) n_state = ST_D2A;
            end
            ST_D2A: n_state = ST_D2B;
            ST_D2B: n_state = ST_D2C;
            ST_D2C: begin
                if (nc_eff != '0)      n_state = ST_C0;
                else if (nr_eff != '0) n_state = ST_RI;
                else                   n_state = ST_OUT;
            end
            ST_C0:  n_state = ST_C1;
            ST_C1:  n_state = ST_C2;
            ST_C2:  n_state = ST_C3;
            ST_C3:  n_state = ST_C4;
            ST_C4:  n_state = ST_C5;
            ST_C5:  n_state = ST_C6;
            ST_C6:  n_state = ST_C7;
            ST_C7:  n_state = ST_C8;
            ST_C8:  n_state = ST_C9;
            ST_C9:  n_state = ST_C10;
            ST_C10: n_state = ST_C11;
            ST_C11: begin
                if (!last_circ)        n_state = ST_C0;
                else if (nr_eff != '0) n_state = ST_RI;
                else                   n_state = ST_OUT;
            end
            ST_RI:  n_state = ST_E0;
            ST_E0:  n_state = ST_E1;
            ST_E1:  n_state = ST_E2;
            ST_E2:  n_state = ST_E3;
            ST_E3:  n_state = ST_E4;
            ST_E4:  n_state = ST_E5;
            ST_E5:  n_state = ST_E6;
            ST_E6: begin
                if (r_edge != 2'd3) n_state = ST_E0;
                else if (!last_rect) n_state = ST_RI;
                else                 n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // shared unit operand selection
    always_comb begin
        mac_ctl = '{mode: MAC_HOLD, a: '0, b: '0};
        unique case (r_state)
            ST_D2A: mac_ctl = '{MAC_LOAD, MUL_W'(r_dx), MUL_W'(r_dx)};
            ST_D2B: mac_ctl = '{MAC_ADD,  MUL_W'(r_dy), MUL_W'(r_dy)};
            ST_C0:  mac_ctl = '{MAC_LOAD, MUL_W'(dxs), MUL_W'(dxs)};
            ST_C1:  mac_ctl = '{MAC_ADD,  MUL_W'(dys), MUL_W'(dys)};
            ST_C2:  mac_ctl = '{MAC_LOAD, MUL_W'(c_rad), MUL_W'(c_rad)};
            ST_C3:  mac_ctl = '{MAC_LOAD, MUL_W'(dxe), MUL_W'(dxe)};
            ST_C4:  mac_ctl = '{MAC_ADD,  MUL_W'(dye), MUL_W'(dye)};
            ST_C5:  mac_ctl = '{MAC_LOAD, MUL_W'(wx), MUL_W'(r_dx)};
            ST_C6:  mac_ctl = '{MAC_ADD,  MUL_W'(wy), MUL_W'(r_dy)};
            ST_C7:  mac_ctl = '{MAC_LOAD, MUL_W'(wx), MUL_W'(r_dy)};
            ST_C8:  mac_ctl = '{MAC_SUB,  MUL_W'(wy), MUL_W'(r_dx)};
            ST_C9:  mac_ctl = '{MAC_LOAD, MUL_W'(r_rr), MUL_W'(r_d2)};
            ST_C10: mac_ctl = '{MAC_LOAD, MUL_W'(r_cr), MUL_W'(r_cr)};
            ST_E0:  mac_ctl = '{MAC_LOAD, MUL_W'(v2x), MUL_W'(ndy)};
            ST_E1:  mac_ctl = '{MAC_ADD,  MUL_W'(v2y), MUL_W'(r_dx)};
            ST_E2:  mac_ctl = '{MAC_LOAD, MUL_W'(v2x), MUL_W'(v1y)};
            ST_E3:  mac_ctl = '{MAC_SUB,  MUL_W'(v1x), MUL_W'(v2y)};
            ST_E4:  mac_ctl = '{MAC_LOAD, MUL_W'(v1x), MUL_W'(ndy)};
            ST_E5:  mac_ctl = '{MAC_ADD,  MUL_W'(v1y), MUL_W'(r_dx)};
            default: mac_ctl = '{mode: MAC_HOLD, a: '0, b: '0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pad       <= '0;
            r_nc        <= '0;
            r_nr        <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_edge      <= '0;
            r_inside    <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg'(i_cfg_index))
                    CFG_PADDING: r_pad <= i_cfg_data;
                    CFG_CIRCLES: r_nc  <= i_cfg_data[CNT_WIDTH-1:0];
                    CFG_RECTS:   r_nr  <= i_cfg_data[CNT_WIDTH-1:0];
                    CFG_UNUSED:  ;
                    default:     ;
                endcase
            end
            // new word from a write, a no-op word or a finished check, else drop a taken word
            if (in_acc && op != OP_CHECK) begin
                r_out_valid  <= 1'b1;
                r_out_coll   <= 1'b0;
                r_out_inside <= 1'b0;
            end else if (r_state == ST_OUT && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_coll   <= r_hit || r_inside;
                r_out_inside <= r_inside;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && op == OP_CHECK) begin
                r_sx     <= i_start_x;
                r_sy     <= i_start_y;
                r_ex     <= i_end_x;
                r_ey     <= i_end_y;
                r_dx     <= 17'(i_end_x) - 17'(i_start_x);
                r_dy     <= 17'(i_end_y) - 17'(i_start_y);
                r_inside <= 1'b0;
                r_hit    <= 1'b0;
                r_idx    <= '0;
                r_edge   <= '0;
            end
            unique case (r_state)
                ST_D2C: r_d2 <= acc;
                ST_C2:  r_t  <= acc;
                ST_C3: begin
                    r_rr <= acc;
                    if (r_t <= acc) r_inside <= 1'b1;
                end
                ST_C5: begin
                    if (acc <= r_rr) r_inside <= 1'b1;
                end
                ST_C7:  r_nok <= (acc >= ACC_ZERO) && (acc <= r_d2) && (r_d2 != '0);
                ST_C9:  r_cr  <= (acc < ACC_ZERO) ? -acc : acc;
                ST_C10: r_t   <= acc;
                ST_C11: begin
                    if (r_nok && acc <= r_t) r_hit <= 1'b1;
                    r_idx <= last_circ ? '0 : r_idx + 1'b1;
                end
                ST_RI: begin
                    if (ri_hit) r_inside <= 1'b1;
                    r_edge <= '0;
                end
                ST_E2:  r_den <= acc;
                ST_E4:  r_n1  <= acc;
                ST_E6: begin
                    if (cross_ok) r_hit <= 1'b1;
                    r_edge <= r_edge + 1'b1;
                    if (r_edge == 2'd3) r_idx <= r_idx + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_collision       = r_out_coll;
    assign o_endpoint_inside = r_out_inside;

endmodule

>>> rtl/soc_mac.sv
// shared multiply-accumulate unit, one product per cycle into a wide accumulator
// depends on soc_pkg
module soc_mac
    import soc_pkg::*;
(
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [2*MUL_W-1:0] prod;
    logic signed [ACC_W-1:0]   r_acc;

    assign prod  = i_ctl.a * i_ctl.b;
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.mode)
            MAC_HOLD: r_acc <= r_acc;
            MAC_LOAD: r_acc <= ACC_W'(prod);
            MAC_ADD:  r_acc <= r_acc + ACC_W'(prod);
            MAC_SUB:  r_acc <= r_acc - ACC_W'(prod);
            default:  r_acc <= r_acc;
        endcase
    end

endmodule

>>> rtl/soc_tables.sv
// circle and rectangle obstacle tables, one write and one read slot each
// depends on soc_pkg
module soc_tables
    import soc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we_circ,
    input  logic                 i_we_rect,
    input  logic [IDX_WIDTH-1:0] i_wr_idx,
    input  t_circ                i_circ,
    input  t_rect                i_rect,
    input  logic [IDX_WIDTH-1:0] i_rd_idx,
    output t_circ                o_circ,
    output t_rect                o_rect
);

    t_circ r_circ_tab [MAX_CIRCLES];
    t_rect r_rect_tab [MAX_RECTS];

    always_ff @(posedge i_clk) begin
        if (i_we_circ) begin
            r_circ_tab[i_wr_idx] <= i_circ;
        end
        if (i_we_rect) begin
            r_rect_tab[i_wr_idx] <= i_rect;
        end
    end

    assign o_circ = r_circ_tab[i_rd_idx];
    assign o_rect = r_rect_tab[i_rd_idx];

endmodule

>>> rtl/soc_checker.sv
// port-level checks for the collision checker, bound to the top level
// depends on soc_pkg and segment_obstacle_collision_check_top
module soc_checker
    import soc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_operation,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_collision,
    input logic       o_endpoint_inside
);

    // held word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation == OP_CHECK |=> o_in_stall)
        else $error("input not stalled during a check");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation != OP_CHECK
        |=> o_out_valid && !o_collision && !o_endpoint_inside)
        else $error("table write did not give a zero word");

    a_inside_coll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_endpoint_inside |-> o_collision)
        else $error("endpoint inside without collision");

endmodule

bind segment_obstacle_collision_check_top soc_checker u_soc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_operation       (i_operation),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_collision       (o_collision),
    .o_endpoint_inside (o_endpoint_inside)
);

>>> verif/tb.sv
// testbench for segment_obstacle_collision_check_top: random and directed words,
// a predicting scoreboard and randomly stalled handshakes; depends on soc_pkg and the rtl
module tb;
    import soc_pkg::*;

    typedef struct {
        logic [1:0]        op;
        logic [3:0]        idx;
        logic signed [15:0] ox, oy;
        logic [14:0]       ea, eb;
        logic signed [15:0] sx, sy, ex, ey;
    } t_seg_word;

    typedef struct {
        bit collision;
        bit endpt_in;
    } t_hit_flags;

    class collision_scoreboard;
        longint cx[16], cy[16], cr[16];
        longint rx[16], ry[16], rw[16], rh[16];
        longint pad;
        int     n_circ, n_rect;
        t_hit_flags pending[$];

        function void set_reg(t_cfg idx, logic [11:0] val);
            case (idx)
                CFG_PADDING: pad = val;
                CFG_CIRCLES: n_circ = val[4:0];
                CFG_RECTS:   n_rect = val[4:0];
                default: ;
            endcase
        endfunction

        function bit point_hit(longint px, longint py, int nc, int nr);
            longint dx, dy, r;
            for (int i = 0; i < nc; i++) begin
                dx = px - cx[i];
                dy = py - cy[i];
                r = cr[i] + pad;
                if (dx * dx + dy * dy <= r * r) return 1;
            end
            for (int i = 0; i < nr; i++) begin
                dx = px - rx[i];
                dy = py - ry[i];
                if (dx >= -pad && dx <= rw[i] + pad && dy >= -pad && dy <= rh[i] + pad)
                    return 1;
            end
            return 0;
        endfunction

        // segment o + t*d against edge a..b, both parameters inclusive in [0,1]
        function bit edge_cross(longint ox, longint oy, longint dx, longint dy,
                                longint ax, longint ay, longint bx, longint by);
            longint v1x, v1y, v2x, v2y, den, n1, n2;
            v1x = ox - ax; v1y = oy - ay;
            v2x = bx - ax; v2y = by - ay;
            den = -v2x * dy + v2y * dx;
            if (den == 0) return 0;
            n1 = v2x * v1y - v1x * v2y;
            n2 = -v1x * dy + v1y * dx;
            if (den < 0) begin
                den = -den; n1 = -n1; n2 = -n2;
            end
            return n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den;
        endfunction

        function bit circle_pass(longint ox, longint oy, longint dx, longint dy, int i);
            longint d2, wx, wy, n, c, r;
            logic [127:0] lhs, rhs;
            d2 = dx * dx + dy * dy;
            if (d2 == 0) return 0;
            wx = cx[i] - ox;
            wy = cy[i] - oy;
            n = wx * dx + wy * dy;
            if (n < 0 || n > d2) return 0;
            c = wx * dy - wy * dx;
            if (c < 0) c = -c;
            r = cr[i] + pad;
            lhs = 128'(c) * 128'(c);
            rhs = 128'(r * r) * 128'(d2);
            return lhs <= rhs;
        endfunction

        function void note_word(t_seg_word w);
            t_hit_flags res;
            longint sx, sy, ex, ey, dx, dy, x0, y0, x1, y1;
            int nc, nr;
            res = '{0, 0};
            case (t_op'(w.op))
                OP_WR_CIRC: begin
                    cx[w.idx] = w.ox; cy[w.idx] = w.oy; cr[w.idx] = w.ea;
                end
                OP_WR_RECT: begin
                    rx[w.idx] = w.ox; ry[w.idx] = w.oy;
                    rw[w.idx] = w.ea; rh[w.idx] = w.eb;
                end
                OP_CHECK: begin
                    sx = w.sx; sy = w.sy; ex = w.ex; ey = w.ey;
                    dx = ex - sx; dy = ey - sy;
                    nc = n_circ > 16 ? 16 : n_circ;
                    nr = n_rect > 16 ? 16 : n_rect;
                    res.endpt_in = point_hit(sx, sy, nc, nr) || point_hit(ex, ey, nc, nr);
                    res.collision = res.endpt_in;
                    for (int i = 0; i < nr && !res.collision; i++) begin
                        x0 = rx[i] - pad; y0 = ry[i] - pad;
                        x1 = rx[i] + rw[i] + pad; y1 = ry[i] + rh[i] + pad;
                        res.collision = edge_cross(sx, sy, dx, dy, x0, y0, x1, y0) ||
                                        edge_cross(sx, sy, dx, dy, x1, y0, x1, y1) ||
                                        edge_cross(sx, sy, dx, dy, x1, y1, x0, y1) ||
                                        edge_cross(sx, sy, dx, dy, x0, y1, x0, y0);
                    end
                    for (int i = 0; i < nc && !res.collision; i++)
                        res.collision = circle_pass(sx, sy, dx, dy, i);
                end
                default: ;
            endcase
            pending = {pending, res};
        endfunction

        // empty string when the word matches the oldest expectation
        function string check_result(bit col, bit ins);
            t_hit_flags e;
            if (pending.size() == 0) return "result word with nothing expected";
            e = pending.pop_front();
            if (e.collision !== col || e.endpt_in !== ins)
                return $sformatf("collision %0d/%0d endpoint_inside %0d/%0d (got/exp)",
                                 col, e.collision, ins, e.endpt_in);
            return "";
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [PAD_WIDTH-1:0]   i_cfg_data = '0;
    logic                   i_in_valid = 0;
    logic                   o_in_stall;
    logic [1:0]             i_operation = '0;
    logic [IDX_WIDTH-1:0]   i_entry_index = '0;
    logic signed [15:0]     i_obstacle_x = '0, i_obstacle_y = '0;
    logic [EXT_WIDTH-1:0]   i_obstacle_extent_a = '0, i_obstacle_extent_b = '0;
    logic signed [15:0]     i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 0;
    logic                   o_collision;
    logic                   o_endpoint_inside;

    segment_obstacle_collision_check_top u_dut (.*);

    collision_scoreboard sb = new();
    int  n_fail = 0;
    bit  quiet = 0;
    int  hold_req = 0, hold_done = 0, hold_left = 0;
    longint cycles = 0;

    initial forever #10 i_clk = ~i_clk;

    task report(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        n_fail++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 10000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // monitors: accepted input words and result words
    always @(posedge i_clk) begin
        t_seg_word w;
        string msg;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            w.op = i_operation; w.idx = i_entry_index;
            w.ox = i_obstacle_x; w.oy = i_obstacle_y;
            w.ea = i_obstacle_extent_a; w.eb = i_obstacle_extent_b;
            w.sx = i_start_x; w.sy = i_start_y; w.ex = i_end_x; w.ey = i_end_y;
            sb.note_word(w);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            msg = sb.check_result(o_collision, o_endpoint_inside);
            if (msg != "") report(msg);
        end
    end

    // receiver stalls; a long hold-off lets the block back up into its input
    always @(posedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 11);
        end
    end

    task write_reg(t_cfg idx, logic [11:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task send_word(t_seg_word w);
        i_in_valid <= 1;
        i_operation <= w.op; i_entry_index <= w.idx;
        i_obstacle_x <= w.ox; i_obstacle_y <= w.oy;
        i_obstacle_extent_a <= w.ea; i_obstacle_extent_b <= w.eb;
        i_start_x <= w.sx; i_start_y <= w.sy; i_end_x <= w.ex; i_end_y <= w.ey;
        do @(posedge i_clk); while (o_in_stall);
        if (!quiet && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // drop valid first so the last word is not taken twice
    task wait_drained();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function logic signed [15:0] rand_coord(bit near);
        if (near) return 16'($urandom_range(0, 4000)) - 16'sd2000;
        return 16'($urandom());
    endfunction

    function t_seg_word rand_word(t_op op);
        t_seg_word w;
        bit near;
        near = $urandom_range(0, 99) < 75;
        w.op = op; w.idx = 4'($urandom());
        w.ox = rand_coord(near); w.oy = rand_coord(near);
        w.ea = near ? 15'($urandom_range(0, 1500)) : 15'($urandom());
        w.eb = near ? 15'($urandom_range(0, 1500)) : 15'($urandom());
        w.sx = rand_coord(near); w.sy = rand_coord(near);
        w.ex = rand_coord(near); w.ey = rand_coord(near);
        case ($urandom_range(0, 19))
            0: begin w.ex = w.sx; w.ey = w.sy; end  // degenerate segment
            1: w.ey = w.sy;                         // parallel to horizontal edges
            2: w.ex = w.sx;                         // parallel to vertical edges
            default: ;
        endcase
        return w;
    endfunction

    function t_seg_word make_word(t_op op, int idx, int ox, int oy, int ea, int eb,
                                  int sx, int sy, int ex, int ey);
        t_seg_word w;
        w.op = op; w.idx = 4'(idx); w.ox = 16'(ox); w.oy = 16'(oy);
        w.ea = 15'(ea); w.eb = 15'(eb);
        w.sx = 16'(sx); w.sy = 16'(sy); w.ex = 16'(ex); w.ey = 16'(ey);
        return w;
    endfunction

    initial begin
        t_seg_word w;
        int r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_reg(CFG_PADDING, 12'd0);
        write_reg(CFG_CIRCLES, 12'd0);
        write_reg(CFG_RECTS, 12'd0);
        write_reg(CFG_UNUSED, 12'hFFF);

        // fill both tables so no unwritten entry is ever checked
        send_word(make_word(OP_WR_CIRC, 0, 0, 0, 160, 0, 0, 0, 0, 0));
        send_word(make_word(OP_WR_RECT, 0, 1000, 1000, 320, 160, 0, 0, 0, 0));
        send_word(make_word(OP_WR_CIRC, 15, -32768, -32768, 32767, 32767, 0, 0, 0, 0));
        send_word(make_word(OP_WR_RECT, 15, 32767, 32767, 32767, 32767, 0, 0, 0, 0));
        for (int i = 1; i < 15; i++) begin
            send_word(rand_word(OP_WR_CIRC));
            w = rand_word(OP_WR_RECT);
            w.idx = i;
            send_word(w);
            w = rand_word(OP_WR_CIRC);
            w.idx = i;
            send_word(w);
        end
        wait_drained();
        write_reg(CFG_CIRCLES, 12'd1);
        write_reg(CFG_RECTS, 12'd1);

        // directed checks against the first circle and rectangle
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 50, 50, 50, 50));         // point in circle
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 160, 0, 160, 0));         // on circle rim
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 500, 500, 500, 500));     // degenerate, clear
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, -400, 100, 400, 100));    // passes circle
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 300, 300, 600, 600));     // projection before start
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 1100, 900, 1100, 1300));  // crosses rectangle
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 900, 1000, 1400, 1000));  // along an edge
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 1320, 900, 1320, 950));   // short of corner
        send_word(make_word(OP_NONE, 3, -1, -1, 32767, 32767, -1, -1, -1, -1));
        wait_drained();
        write_reg(CFG_PADDING, 12'd4095);
        write_reg(CFG_CIRCLES, 12'd16);
        write_reg(CFG_RECTS, 12'd16);
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, -32768, -32768, 32767, 32767));
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 32767, -32768, -32768, 32767));
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 32767, -32768, 32767, -32768));
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 1500, 1500, 1500, 1500));
        wait_drained();
        write_reg(CFG_CIRCLES, 12'd31);
        write_reg(CFG_RECTS, 12'd31);
        send_word(make_word(OP_CHECK, 0, 0, 0, 0, 0, 20000, -20000, 21000, -20000));

        for (int ph = 0; ph < 18; ph++) begin
            wait_drained();
            case (ph % 3)
                0: write_reg(CFG_PADDING, 12'd0);
                1: write_reg(CFG_PADDING, 12'd4095);
                default: write_reg(CFG_PADDING, 12'($urandom_range(0, 300)));
            endcase
            if (ph == 5 || ph == 12) begin
                write_reg(CFG_CIRCLES, ph == 5 ? 12'd16 : 12'd31);
                write_reg(CFG_RECTS, ph == 5 ? 12'd31 : 12'd16);
            end else begin
                write_reg(CFG_CIRCLES, 12'($urandom_range(0, 4)));
                write_reg(CFG_RECTS, 12'($urandom_range(0, 4)));
            end
            quiet = (ph == 2);
            for (int n = 0; n < 100; n++) begin
                if (ph == 7 && n == 10) hold_req++;
                r = $urandom_range(0, 99);
                if (r < 18) send_word(rand_word(OP_WR_CIRC));
                else if (r < 36) send_word(rand_word(OP_WR_RECT));
                else if (r < 39) send_word(rand_word(OP_NONE));
                else send_word(rand_word(OP_CHECK));
            end
            quiet = 0;
        end

        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/soc_pkg.sv
rtl/soc_mac.sv
rtl/soc_tables.sv
rtl/segment_obstacle_collision_check_top.sv
rtl/soc_checker.sv
verif/tb.sv
